/* hdl/cic_pkg.sv */
// shared types, constants and helpers for the concurrent interval counter
package cic_pkg;

  localparam int SLOT_W       = 17;
  localparam int OFFSET_W     = 17;
  localparam int COUNT_W      = 11;
  localparam int COUNT_MAX    = 2047;
  localparam int SEC_PER_HOUR = 3600;
  localparam int SEC_PER_MIN  = 60;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e_t;

  typedef struct packed {
    logic [1:0] command;
    logic [4:0] start_hour;
    logic [5:0] start_minute;
    logic [5:0] start_second;
    logic [4:0] end_hour;
    logic [5:0] end_minute;
    logic [5:0] end_second;
  } in_item_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] time_offset;
    logic [COUNT_W-1:0]  task_count;
    logic                negative_error;
    logic                point_valid;
    logic                last_point;
    logic                add_rejected;
  } out_item_t;

  // commands from controller to datapath
  typedef struct packed {
    logic in_take;
    logic sweep_start;
    logic sweep_step;
    logic add_issue_s;
    logic add_write_s;
    logic add_issue_e;
    logic add_write_e;
    logic set_reject;
    logic scan_start;
    logic scan_step;
    logic take_cur;
    logic finish_nxt;
    logic exhaust;
    logic res_zero;
    logic out_load;
  } ctl_t;

  // status from datapath to controller
  typedef struct packed {
    logic add_ok;
    logic readout_done;
    logic scan_hit;
    logic scan_end;
    logic sweep_last;
    logic out_free;
  } sts_t;

  function automatic logic [SLOT_W-1:0] clock_to_slot(logic [4:0] h, logic [5:0] m,
                                                      logic [5:0] s);
    return SLOT_W'(h) * SLOT_W'(SEC_PER_HOUR) + SLOT_W'(m) * SLOT_W'(SEC_PER_MIN) + SLOT_W'(s);
  endfunction

endpackage

/* hdl/cic_stream_if.sv */
// valid/ready channel carrying one word of a given payload type
interface cic_stream_if #(parameter type data_t = logic);
  logic  valid;
  logic  ready;
  data_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

/* hdl/cic_ram.sv */
// generic single-write, single-read ram with registered read data
module cic_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 131072,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* hdl/cic_ctrl.sv */
// controller state machine: sequences add, read-scan, clear sweep and result hand-off
module cic_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  input  logic [1:0]    item_command,
  output logic          item_ready,
  input  cic_pkg::sts_t sts,
  output cic_pkg::ctl_t ctl
);
  import cic_pkg::*;

  typedef enum logic [9:0] {
    ST_SWEEP     = 10'b00_0000_0001,
    ST_IDLE      = 10'b00_0000_0010,
    ST_ADD_RS    = 10'b00_0000_0100,
    ST_ADD_WS    = 10'b00_0000_1000,
    ST_ADD_RE    = 10'b00_0001_0000,
    ST_ADD_WE    = 10'b00_0010_0000,
    ST_SCAN_CUR  = 10'b00_0100_0000,
    ST_SCAN_NXT  = 10'b00_1000_0000,
    ST_CLR_SWEEP = 10'b01_0000_0000,
    ST_EMIT      = 10'b10_0000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  assign item_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    ctl        = '0;
    unique case (state)
      ST_SWEEP: begin
        ctl.sweep_step = 1'b1;
        if (sts.sweep_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (item_valid) begin
          ctl.in_take = 1'b1;
          unique case (item_command)
            CMD_ADD: begin
              state_next = ST_ADD_RS;
            end
            CMD_READ: begin
              if (sts.readout_done) begin
                ctl.res_zero = 1'b1;
                state_next   = ST_EMIT;
              end else begin
                ctl.scan_start = 1'b1;
                state_next     = ST_SCAN_CUR;
              end
            end
            CMD_CLEAR: begin
              ctl.sweep_start = 1'b1;
              ctl.res_zero    = 1'b1;
              state_next      = ST_CLR_SWEEP;
            end
            default: begin
              ctl.res_zero = 1'b1;
              state_next   = ST_EMIT;
            end
          endcase
        end
      end
      ST_ADD_RS: begin
        if (sts.add_ok) begin
          ctl.add_issue_s = 1'b1;
          state_next      = ST_ADD_WS;
        end else begin
          ctl.set_reject = 1'b1;
          state_next     = ST_EMIT;
        end
      end
      ST_ADD_WS: begin
        ctl.add_write_s = 1'b1;
        state_next      = ST_ADD_RE;
      end
      ST_ADD_RE: begin
        ctl.add_issue_e = 1'b1;
        state_next      = ST_ADD_WE;
      end
      ST_ADD_WE: begin
        ctl.add_write_e = 1'b1;
        ctl.res_zero    = 1'b1;
        state_next      = ST_EMIT;
      end
      ST_SCAN_CUR: begin
        priority if (sts.scan_hit) begin
          ctl.take_cur = 1'b1;
          state_next   = ST_SCAN_NXT;
        end else if (sts.scan_end) begin
          ctl.exhaust = 1'b1;
          state_next  = ST_EMIT;
        end else begin
          ctl.scan_step = 1'b1;
        end
      end
      ST_SCAN_NXT: begin
        if (sts.scan_hit || sts.scan_end) begin
          ctl.finish_nxt = 1'b1;
          state_next     = ST_EMIT;
        end else begin
          ctl.scan_step = 1'b1;
        end
      end
      ST_CLR_SWEEP: begin
        ctl.sweep_step = 1'b1;
        if (sts.sweep_last) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_SWEEP;
      end
    endcase
  end
endmodule

/* hdl/cic_dp.sv */
// datapath: slot store, scan pointer, running sum, result and output registers
module cic_dp #(
  parameter int MAX_INTERVALS = 1024,
  parameter int TIME_SLOTS    = 131072
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cic_pkg::in_item_t    item_data,
  input  cic_pkg::ctl_t        ctl,
  output cic_pkg::sts_t        sts,
  output logic                 out_valid,
  output cic_pkg::out_item_t   out_data,
  input  logic                 out_ready
);
  import cic_pkg::*;

  localparam int AW = $clog2(TIME_SLOTS);
  localparam int PW = AW + 1;
  localparam int CW = $clog2(MAX_INTERVALS + 1);
  localparam int DW = CW + 1;
  localparam int MW = DW + 1;
  localparam int EW = SLOT_W + 1;
  localparam int TW = (DW > COUNT_W) ? DW : COUNT_W + 1;

  // store word: used flag over signed delta
  logic [MW-1:0] wdata, rdata;
  logic [AW-1:0] waddr, raddr;
  logic          we;
  logic [DW-1:0] rd_delta;

  logic [SLOT_W-1:0] s_slot;
  logic [EW-1:0]     e_slot;
  logic [CW-1:0]     interval_count;
  logic [PW-1:0]     read_slot;
  logic [DW-1:0]     running_total, total_next;
  logic [AW-1:0]     base_slot, cur_slot;
  logic              base_found, readout_done;
  logic [PW-1:0]     probe;
  logic              pv;
  logic [AW-1:0]     paddr;
  logic [AW-1:0]     clr_addr;
  out_item_t         res, point;
  logic              probe_lt;

  cic_ram #(.WIDTH(MW), .DEPTH(TIME_SLOTS)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign rd_delta = rdata[DW-1:0];
  assign probe_lt = probe < PW'(TIME_SLOTS);

  always_comb begin
    we    = 1'b0;
    waddr = clr_addr;
    wdata = '0;
    if (ctl.sweep_step) begin
      we = 1'b1;
    end else if (ctl.add_write_s) begin
      we    = 1'b1;
      waddr = s_slot[AW-1:0];
      wdata = {1'b1, rd_delta + DW'(1)};
    end else if (ctl.add_write_e) begin
      we    = 1'b1;
      waddr = e_slot[AW-1:0];
      wdata = {1'b1, rd_delta - DW'(1)};
    end
  end

  always_comb begin
    priority if (ctl.add_issue_s) raddr = s_slot[AW-1:0];
    else if (ctl.add_issue_e)     raddr = e_slot[AW-1:0];
    else                          raddr = probe[AW-1:0];
  end

  assign sts.add_ok       = (interval_count < CW'(MAX_INTERVALS)) && (e_slot < EW'(TIME_SLOTS));
  assign sts.readout_done = readout_done;
  assign sts.scan_hit     = pv && rdata[MW-1];
  assign sts.scan_end     = !pv && !probe_lt;
  assign sts.sweep_last   = (clr_addr == AW'(TIME_SLOTS - 1));
  assign sts.out_free     = !out_valid || out_ready;

  assign total_next = running_total + rd_delta;

  // point result from the registered current slot and sum
  always_comb begin
    point             = '0;
    point.time_offset = OFFSET_W'(cur_slot - base_slot);
    point.point_valid = 1'b1;
    point.last_point  = !sts.scan_hit;
    if (running_total[DW-1]) begin
      point.negative_error = 1'b1;
    end else if (TW'(running_total) > TW'(COUNT_MAX)) begin
      point.task_count = COUNT_W'(COUNT_MAX);
    end else begin
      point.task_count = COUNT_W'(running_total);
    end
  end

  // add operands, scan pointer, result and output registers
  always_ff @(posedge clk) begin
    if (ctl.in_take) begin
      s_slot <= clock_to_slot(item_data.start_hour, item_data.start_minute,
                              item_data.start_second);
      e_slot <= EW'(clock_to_slot(item_data.end_hour, item_data.end_minute,
                                  item_data.end_second)) + EW'(1);
    end
    if (ctl.scan_start) begin
      probe <= read_slot;
    end else if (ctl.take_cur) begin
      probe <= PW'(paddr) + PW'(1);
    end else if (ctl.scan_step && probe_lt) begin
      probe <= probe + PW'(1);
    end
    if (ctl.scan_step) paddr <= probe[AW-1:0];
    if (ctl.take_cur) cur_slot <= paddr;
    if (ctl.out_load) out_data <= res;
    if (ctl.set_reject) begin
      res <= '{add_rejected: 1'b1, default: '0};
    end else if (ctl.res_zero || ctl.exhaust) begin
      res <= '0;
    end else if (ctl.finish_nxt) begin
      res <= point;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.sweep_start) begin
      interval_count <= '0;
      read_slot      <= '0;
      running_total  <= '0;
      base_slot      <= '0;
      base_found     <= 1'b0;
      readout_done   <= 1'b0;
      clr_addr       <= '0;
      pv             <= 1'b0;
    end else begin
      if (ctl.sweep_step) clr_addr <= clr_addr + AW'(1);
      if (ctl.add_write_e) interval_count <= interval_count + CW'(1);
      if (ctl.scan_start || ctl.take_cur) begin
        pv <= 1'b0;
      end else if (ctl.scan_step) begin
        pv <= probe_lt;
      end
      if (ctl.take_cur) begin
        running_total <= total_next;
        if (!base_found) begin
          base_found <= 1'b1;
          base_slot  <= paddr;
        end
      end
      if (ctl.finish_nxt) begin
        read_slot <= sts.scan_hit ? PW'(paddr) : PW'(TIME_SLOTS);
      end
      if (ctl.exhaust) begin
        readout_done <= 1'b1;
        read_slot    <= PW'(TIME_SLOTS);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end
endmodule

/* hdl/concurrent_interval_count_top.sv */
// top level of the concurrent interval counter: controller, datapath and checks
// Usage: each word on item carries a command (add interval, read next point, clear)
// and start/end clock times; every accepted word yields exactly one word on result.
// The delta store is one ram of TIME_SLOTS words, indexed by clock time in seconds.
// After reset the ram is swept to zero at one word a cycle: item.ready stays low until
// all TIME_SLOTS words (131072 by default) are cleared. A clear command runs the same
// sweep and returns its result word after it.
// An add does a read-modify-write of the start slot and of the end slot plus one on
// the one ram: start read, start write, end read, end write, then the result word;
// the next word is accepted after that. A rejected add goes straight to its result.
// A read scans the ram one slot a cycle from the stored read position up to the point
// slot and on to the next used slot; the read that exhausts the store scans to the
// end of the store, and later reads return an empty word without a scan.
// The result sits in an output register: a new word can be accepted while it waits.
// If the receiver stalls, the next result is held in the datapath and the block stops
// accepting until the output register frees up; nothing is dropped.
module concurrent_interval_count_top #(
  parameter int MAX_INTERVALS = 1024,
  parameter int TIME_SLOTS    = 131072
) (
  input logic         clk,
  input logic         rst,
  cic_stream_if.sink   item,
  cic_stream_if.source result
);
  import cic_pkg::*;

  ctl_t      ctl;
  sts_t      sts;
  in_item_t  item_word;
  out_item_t result_word;

  assign item_word   = item.data;
  assign result.data = result_word;

  cic_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item.valid),
    .item_command(item_word.command),
    .item_ready  (item.ready),
    .sts         (sts),
    .ctl         (ctl)
  );

  cic_dp #(
    .MAX_INTERVALS(MAX_INTERVALS),
    .TIME_SLOTS   (TIME_SLOTS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .item_data(item_word),
    .ctl      (ctl),
    .sts      (sts),
    .out_valid(result.valid),
    .out_data (result_word),
    .out_ready(result.ready)
  );

  // no word is taken while the store is being swept
  a_sweep_blocks_input: assert property (@(posedge clk) disable iff (rst)
    ctl.sweep_step |-> !item.ready)
    else $error("input accepted during store sweep");

  // a result is only loaded when the output register is free
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |-> sts.out_free)
    else $error("output register overwritten");

  // a point and a rejected add never share a word
  a_point_not_reject: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result_word.point_valid && result_word.add_rejected))
    else $error("point word flagged as rejected add");

  // a negative count reads zero
  a_clamp_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result_word.negative_error) |-> (result_word.task_count == '0))
    else $error("negative count not clamped");

  // a finished read is loaded as soon as the output register is free
  a_point_then_load: assert property (@(posedge clk) disable iff (rst)
    ctl.finish_nxt |=> (result.valid || !sts.out_free || ctl.out_load))
    else $error("finished read not handed to output");
endmodule

/* verif/concurrent_interval_count_top_tb.sv */
// self-checking testbench for concurrent_interval_count_top: sweep-line counter against a predictor
module concurrent_interval_count_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cic_pkg::*;

  localparam int MAX_INTERVALS = 1024;
  localparam int TIME_SLOTS    = 131072;
  localparam int unsigned DAY_END = 24 * SEC_PER_HOUR - 1;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    in_item_t word;
    bit       drain_first;
  } word_plan_t;

  typedef enum {SINK_OPEN, SINK_CHOPPY, SINK_HOLD} sink_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cic_stream_if #(.data_t(in_item_t))  item_if ();
  cic_stream_if #(.data_t(out_item_t)) result_if ();

  concurrent_interval_count_top #(
    .MAX_INTERVALS(MAX_INTERVALS),
    .TIME_SLOTS(TIME_SLOTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .item(item_if),
    .result(result_if)
  );

  // predicted block state
  int          slot_sum [TIME_SLOTS];
  bit          slot_taken [TIME_SLOTS];
  int          intervals_held;
  int unsigned scan_pos;
  int          live_sum;
  int unsigned origin_slot;
  bit          origin_known;
  bit          readout_over;

  out_item_t  due_results[$];
  word_plan_t words_to_send[$];

  // stimulus planning
  bit plan_mark [TIME_SLOTS];
  int plan_slots;
  int seg_adds;
  int seg_reads;
  int total_words;

  // traffic bookkeeping, nonblocking so other processes see settled values
  int words_taken;
  int open_words;

  int mismatches;
  int results_seen;
  int n_adds, n_rejected, n_points, n_negative, n_last, n_empty_reads, n_clears, n_unknown;

  int         burst_left;
  int         gap_left;
  sink_mode_t sink_mode;
  int         stretch_left;
  int         sink_taken;
  bit         long_hold_done;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int unsigned slot_index(logic [4:0] h, logic [5:0] m, logic [5:0] sec);
    return int'(h) * SEC_PER_HOUR + int'(m) * SEC_PER_MIN + int'(sec);
  endfunction

  function automatic int unsigned first_used_from(int unsigned from);
    for (int unsigned i = from; i < TIME_SLOTS; i++) begin
      if (slot_taken[i]) return i;
    end
    return TIME_SLOTS;
  endfunction

  // expected result word for one accepted command, updating the predicted state
  function automatic out_item_t apply_command(in_item_t w);
    out_item_t   r;
    int unsigned s, e, cur, nxt;
    r = '0;
    case (w.command)
      CMD_ADD: begin
        n_adds++;
        s = slot_index(w.start_hour, w.start_minute, w.start_second);
        e = slot_index(w.end_hour, w.end_minute, w.end_second) + 1;
        if (intervals_held >= MAX_INTERVALS || e >= TIME_SLOTS) begin
          r.add_rejected = 1'b1;
          n_rejected++;
        end else begin
          slot_sum[s]++;
          slot_taken[s] = 1'b1;
          slot_sum[e]--;
          slot_taken[e] = 1'b1;
          intervals_held++;
        end
      end
      CMD_READ: begin
        cur = readout_over ? TIME_SLOTS : first_used_from(scan_pos);
        if (cur >= TIME_SLOTS) begin
          readout_over = 1'b1;
          scan_pos = TIME_SLOTS;
          n_empty_reads++;
        end else begin
          if (!origin_known) begin
            origin_known = 1'b1;
            origin_slot = cur;
          end
          // the sum itself is never clamped, only the reported count
          live_sum += slot_sum[cur];
          nxt = first_used_from(cur + 1);
          scan_pos = nxt;
          r.time_offset = OFFSET_W'(cur - origin_slot);
          if (live_sum < 0) begin
            r.negative_error = 1'b1;
            n_negative++;
          end else begin
            r.task_count = COUNT_W'((live_sum > COUNT_MAX) ? COUNT_MAX : live_sum);
          end
          r.point_valid = 1'b1;
          r.last_point = (nxt >= TIME_SLOTS);
          n_points++;
          if (r.last_point) n_last++;
        end
      end
      CMD_CLEAR: begin
        foreach (slot_sum[i]) begin
          slot_sum[i] = 0;
          slot_taken[i] = 1'b0;
        end
        intervals_held = 0;
        scan_pos = 0;
        live_sum = 0;
        origin_slot = 0;
        origin_known = 1'b0;
        readout_over = 1'b0;
        n_clears++;
      end
      default: n_unknown++;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < 100) $display("mismatch: %s", msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d: %s is %0d, expected %0d",
                                results_seen, name, got, want));
  endtask

  function automatic in_item_t clock_add(int h0, int m0, int c0, int h1, int m1, int c1);
    in_item_t w;
    w.command      = CMD_ADD;
    w.start_hour   = 5'(h0);
    w.start_minute = 6'(m0);
    w.start_second = 6'(c0);
    w.end_hour     = 5'(h1);
    w.end_minute   = 6'(m1);
    w.end_second   = 6'(c1);
    return w;
  endfunction

  // non-add word: clock fields carry noise that the block has to ignore
  function automatic in_item_t other_word(logic [1:0] cmd);
    in_item_t    w;
    logic [63:0] noise;
    noise = {$urandom, $urandom};
    w = noise[$bits(in_item_t)-1:0];
    w.command = cmd;
    return w;
  endfunction

  function automatic in_item_t random_add(int unsigned lo, int unsigned span);
    int unsigned s, e;
    case ($urandom_range(0, 9))
      0, 1: begin
        // raw clock fields, past their nominal range as often as not
        return clock_add($urandom_range(0, 31), $urandom_range(0, 63), $urandom_range(0, 63),
                         $urandom_range(0, 31), $urandom_range(0, 63), $urandom_range(0, 63));
      end
      2: begin
        // end before start
        s = lo + $urandom_range(0, span);
        e = (s > 300) ? s - $urandom_range(1, 300) : 0;
      end
      default: begin
        s = lo + $urandom_range(0, span);
        e = s + $urandom_range(0, 400);
      end
    endcase
    if (s > DAY_END) s = DAY_END;
    if (e > DAY_END) e = DAY_END;
    return clock_add(s / SEC_PER_HOUR, s % SEC_PER_HOUR / SEC_PER_MIN, s % SEC_PER_MIN,
                     e / SEC_PER_HOUR, e % SEC_PER_HOUR / SEC_PER_MIN, e % SEC_PER_MIN);
  endfunction

  function automatic in_item_t mixed_word(int unsigned lo, int unsigned span, int read_pct);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 3) return other_word(CMD_UNUSED);
    if (pick < 3 + read_pct) return other_word(CMD_READ);
    return random_add(lo, span);
  endfunction

  // also tracks how many distinct slots the current segment can still read out
  task automatic queue_word(in_item_t w, bit drain);
    word_plan_t  p;
    int unsigned s, e;
    p.word = w;
    p.drain_first = drain;
    words_to_send.push_back(p);
    total_words++;
    case (w.command)
      CMD_ADD: begin
        s = slot_index(w.start_hour, w.start_minute, w.start_second);
        e = slot_index(w.end_hour, w.end_minute, w.end_second) + 1;
        if (seg_adds < MAX_INTERVALS && e < TIME_SLOTS) begin
          seg_adds++;
          if (!plan_mark[s]) plan_slots++;
          plan_mark[s] = 1'b1;
          if (!plan_mark[e]) plan_slots++;
          plan_mark[e] = 1'b1;
        end
      end
      CMD_READ: seg_reads++;
      CMD_CLEAR: begin
        foreach (plan_mark[i]) plan_mark[i] = 1'b0;
        plan_slots = 0;
        seg_adds = 0;
        seg_reads = 0;
      end
      default: ;
    endcase
  endtask

  // enough reads to walk off the end of the store, plus a couple past it
  task automatic queue_readout_tail();
    int n;
    n = (plan_slots > seg_reads) ? plan_slots - seg_reads + 2 : 2;
    repeat (n) queue_word(other_word(CMD_READ), 1'b0);
  endtask

  // sender: bursts of words with random gaps, optional wait for the block to drain
  always @(posedge clk) begin : drive_words
    int took, gave;
    if (rst) begin
      item_if.valid <= 1'b0;
      item_if.data  <= '0;
      burst_left = 1;
      gap_left = 0;
    end else begin
      took = int'(item_if.valid && item_if.ready);
      gave = int'(result_if.valid && result_if.ready);
      if (took != 0) begin
        void'(words_to_send.pop_front());
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
      if (item_if.valid && took == 0) begin
        // word still on offer
      end else if (gap_left > 0) begin
        gap_left--;
        item_if.valid <= 1'b0;
      end else if (words_to_send.size() == 0 ||
                   (words_to_send[0].drain_first && open_words + took - gave != 0)) begin
        item_if.valid <= 1'b0;
      end else begin
        item_if.valid <= 1'b1;
        item_if.data  <= words_to_send[0].word;
      end
    end
  end

  // receiver: open, choppy and held stretches, one long hold to back up the input
  always @(posedge clk) begin : pace_results
    bit take_next;
    if (rst) begin
      result_if.ready <= 1'b0;
      stretch_left = 0;
      sink_mode = SINK_OPEN;
    end else begin
      if (result_if.valid && result_if.ready) sink_taken++;
      if (stretch_left > 0) begin
        stretch_left--;
      end else if (!long_hold_done && sink_taken >= 400) begin
        sink_mode = SINK_HOLD;
        stretch_left = 600;
        long_hold_done = 1'b1;
      end else begin
        case ($urandom_range(0, 19))
          0: begin
            sink_mode = SINK_HOLD;
            stretch_left = $urandom_range(20, 200);
          end
          1, 2, 3, 4, 5, 6, 7: begin
            sink_mode = SINK_OPEN;
            stretch_left = $urandom_range(1, 80);
          end
          default: begin
            sink_mode = SINK_CHOPPY;
            stretch_left = $urandom_range(1, 40);
          end
        endcase
      end
      case (sink_mode)
        SINK_OPEN: take_next = 1'b1;
        SINK_HOLD: take_next = 1'b0;
        default:   take_next = ($urandom_range(0, 2) != 0);
      endcase
      result_if.ready <= take_next;
    end
  end

  // results are checked before the same-edge input word is predicted
  always @(posedge clk) begin : watch_words
    out_item_t seen, want;
    int        took, gave;
    if (!rst) begin
      took = int'(item_if.valid && item_if.ready);
      gave = int'(result_if.valid && result_if.ready);
      if (gave != 0) begin
        seen = result_if.data;
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing due", results_seen));
        end else begin
          want = due_results.pop_front();
          check_field("time_offset", 32'(seen.time_offset), 32'(want.time_offset));
          check_field("task_count", 32'(seen.task_count), 32'(want.task_count));
          check_field("negative_error", 32'(seen.negative_error), 32'(want.negative_error));
          check_field("point_valid", 32'(seen.point_valid), 32'(want.point_valid));
          check_field("last_point", 32'(seen.last_point), 32'(want.last_point));
          check_field("add_rejected", 32'(seen.add_rejected), 32'(want.add_rejected));
        end
        results_seen++;
      end
      if (took != 0) due_results.push_back(apply_command(item_if.data));
      words_taken <= words_taken + took;
      open_words  <= open_words + took - gave;
    end
  end

  initial begin : run_plan
    int unsigned lo;

    // directed: day boundaries, odd fields, unknown command, adds during readout
    queue_word(clock_add(0, 0, 0, 23, 59, 59), 1'b0);
    queue_word(clock_add(23, 59, 59, 23, 59, 59), 1'b0);
    queue_word(clock_add(0, 0, 0, 0, 0, 0), 1'b0);
    queue_word(clock_add(12, 30, 15, 12, 0, 0), 1'b0);
    queue_word(clock_add(31, 63, 63, 31, 63, 63), 1'b0);
    queue_word(clock_add(20, 45, 30, 21, 0, 0), 1'b0);
    queue_word(other_word(CMD_UNUSED), 1'b0);
    repeat (5) queue_word(other_word(CMD_READ), 1'b0);
    queue_word(clock_add(0, 0, 5, 0, 0, 10), 1'b0);
    queue_word(clock_add(22, 0, 0, 23, 30, 0), 1'b0);
    repeat (4) queue_word(other_word(CMD_READ), 1'b0);
    queue_word(clock_add(5, 0, 0, 4, 0, 0), 1'b0);
    queue_word(other_word(CMD_UNUSED), 1'b0);

    // busy window, then read out to exhaustion and clear
    lo = $urandom_range(0, 80000);
    for (int i = 0; i < 120; i++)
      queue_word(mixed_word(lo, 2000, 25), $urandom_range(0, 79) == 0);
    queue_readout_tail();
    queue_word(other_word(CMD_CLEAR), 1'b1);

    lo = $urandom_range(0, 80000);
    for (int i = 0; i < 130; i++)
      queue_word(mixed_word(lo, 3000, 25), $urandom_range(0, 79) == 0);
    queue_readout_tail();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (words_taken != total_words || open_words != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d words: %0d adds (%0d rejected), %0d clears, %0d unknown commands",
             words_taken, n_adds, n_rejected, n_clears, n_unknown);
    $display("readout gave %0d points (%0d clamped negative, %0d last), %0d empty reads",
             n_points, n_negative, n_last, n_empty_reads);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

  // covers the reset sweep, one clear and two full-day readout scans several times over
  initial begin : watchdog
    #6_000_000;
    $display("timeout with %0d words taken and %0d results owed", words_taken, open_words);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
